FILE: hw/rtl/iwd_pkg.sv
`default_nettype none

package iwd_pkg;

	localparam int unsigned YearW    = 12;
	localparam int unsigned IsoYearW = 13;
	localparam int unsigned DayW     = 5;
	localparam int unsigned MonthW   = 4;
	localparam int unsigned OrdW     = 9;
	localparam int unsigned WeekW    = 6;
	localparam int unsigned WdayW    = 3;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [CfgIdxW-1:0] RegMinYear = 2'd0;
	localparam logic [CfgIdxW-1:0] RegMaxYear = 2'd1;

	localparam logic [YearW-1:0] MinYearReset = 12'd1900;
	localparam logic [YearW-1:0] MaxYearReset = 12'd2100;

	localparam logic [13:0] Recip7   = 14'd9363;
	localparam logic [12:0] Recip100 = 13'd5243;

	localparam logic [OrdW-1:0] DaysBefore [16] = '{
		9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
	};

	typedef struct packed {
		logic                 valid;
		logic [OrdW-1:0]      ordinal;
		logic [YearW-1:0]     year;
		logic [2:0]           jan1;
		logic                 long_cur;
		logic                 long_prev;
	} iwd_s1_t;

	typedef struct packed {
		logic                 date_valid;
		logic [OrdW-1:0]      ordinal_day;
		logic [IsoYearW-1:0]  iso_year;
		logic [WeekW-1:0]     iso_week;
		logic [WdayW-1:0]     iso_weekday;
	} iwd_res_t;

	typedef struct packed {
		logic       leap;
		logic [2:0] jan1;
	} iwd_year_t;

	function automatic logic [12:0] div7(logic [12:0] x);
		logic [26:0] p;
		p = 27'(x) * 27'(Recip7);
		return 13'(p >> 16);
	endfunction

	function automatic logic [2:0] mod7(logic [12:0] x);
		logic [12:0] q;
		logic [12:0] r;
		q = div7(x);
		r = x - 13'(q * 13'd7);
		return r[2:0];
	endfunction

	function automatic logic [6:0] div100(logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'(Recip100);
		return 7'(p >> 19);
	endfunction

	// jan1: weekday of 1 January, 0 Sunday .. 6 Saturday
	function automatic iwd_year_t year_props(logic [12:0] y);
		iwd_year_t   r;
		logic [6:0]  q;
		logic [6:0]  qn;
		logic [12:0] n;
		logic [12:0] s;
		logic        is100;
		logic        is400;
		q     = div100(y);
		is100 = (y == 13'(q * 13'd100));
		is400 = is100 && (q[1:0] == 2'd0);
		r.leap = (y[1:0] == 2'd0) && (!is100 || is400);
		n  = y + 13'd399;
		qn = div100(n);
		s  = 13'd1 + n + (n >> 2) - 13'(qn) + 13'(qn >> 2);
		r.jan1 = mod7(s);
		return r;
	endfunction

	function automatic logic long_year(iwd_year_t p);
		return (p.jan1 == 3'd4) || (p.leap && (p.jan1 == 3'd3));
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/iwd_if.sv
`default_nettype none

interface iwd_date_if;
	import iwd_pkg::*;
	logic              valid;
	logic              ready;
	logic [DayW-1:0]   day;
	logic [MonthW-1:0] month;
	logic [YearW-1:0]  year;
	modport source (output valid, day, month, year, input ready);
	modport sink (input valid, day, month, year, output ready);
endinterface

interface iwd_result_if;
	import iwd_pkg::*;
	logic                valid;
	logic                ready;
	logic                date_valid;
	logic [OrdW-1:0]     ordinal_day;
	logic [IsoYearW-1:0] iso_year;
	logic [WeekW-1:0]    iso_week;
	logic [WdayW-1:0]    iso_weekday;
	modport source (output valid, date_valid, ordinal_day, iso_year, iso_week, iso_weekday,
		input ready);
	modport sink (input valid, date_valid, ordinal_day, iso_year, iso_week, iso_weekday,
		output ready);
endinterface

interface iwd_cfg_if;
	import iwd_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [YearW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/iso_week_date_converter.sv
// Pipeline: an accepted request is captured in the input register, then moves into the result
// register once that can advance; the result side is driven from the result register.
// Throughput: one request per cycle; the input register stalls only while it is full
// and the result register is full and held by a low ready on the result side.
// Reset: arst_n clears both pipeline valid flags and loads min_year 1900 and
// max_year 2100; the configuration channel is always ready.
`default_nettype none

module iso_week_date_converter
	import iwd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	iwd_date_if.sink       date,
	iwd_result_if.source   result,
	iwd_cfg_if.sink        cfg
);

	logic [YearW-1:0] min_year_q;
	logic [YearW-1:0] max_year_q;
	logic             v_s1;
	logic             v_s2;
	iwd_s1_t          info_s1;
	iwd_s1_t          info_d;
	iwd_res_t         res_s2;
	iwd_res_t         res_d;
	logic             adv_s1;
	logic             adv_s2;

	assign adv_s2 = !v_s2 || result.ready;
	assign adv_s1 = !v_s1 || adv_s2;

	assign date.ready = adv_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MinYearReset;
			max_year_q <= MaxYearReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				RegMinYear: min_year_q <= cfg.data;
				RegMaxYear: max_year_q <= cfg.data;
				default: ;
			endcase
		end
	end

	iwd_year u_year (
		.day      (date.day),
		.month    (date.month),
		.year     (date.year),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.info     (info_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= date.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && date.valid) begin
			info_s1 <= info_d;
		end
		if (adv_s2 && v_s1) begin
			res_s2 <= res_d;
		end
	end

	iwd_week u_week (
		.info (info_s1),
		.res  (res_d)
	);

	assign result.valid       = v_s2;
	assign result.date_valid  = res_s2.date_valid;
	assign result.ordinal_day = res_s2.ordinal_day;
	assign result.iso_year    = res_s2.iso_year;
	assign result.iso_week    = res_s2.iso_week;
	assign result.iso_weekday = res_s2.iso_weekday;

endmodule

`default_nettype wire

FILE: hw/rtl/iwd_year.sv
`default_nettype none

module iwd_year
	import iwd_pkg::*;
(
	input  wire logic [DayW-1:0]   day,
	input  wire logic [MonthW-1:0] month,
	input  wire logic [YearW-1:0]  year,
	input  wire logic [YearW-1:0]  min_year,
	input  wire logic [YearW-1:0]  max_year,
	output iwd_s1_t                info
);

	iwd_year_t        cur;
	iwd_year_t        prev;
	logic [DayW-1:0]  mdays;
	logic             year_ok;
	logic             month_ok;
	logic             day_ok;

	always_comb begin
		cur  = year_props({1'b0, year});
		prev = year_props({1'b0, year} - 13'd1);

		if (month == 4'd2) begin
			mdays = cur.leap ? 5'd29 : 5'd28;
		end else if (month <= 4'd7) begin
			mdays = month[0] ? 5'd31 : 5'd30;
		end else begin
			mdays = month[0] ? 5'd30 : 5'd31;
		end

		year_ok  = (year != '0) && (year >= min_year) && (year <= max_year);
		month_ok = (month >= 4'd1) && (month <= 4'd12);
		day_ok   = (day >= 5'd1) && (day <= mdays);

		info.valid     = year_ok && month_ok && day_ok;
		info.ordinal   = DaysBefore[month] + OrdW'(cur.leap && (month > 4'd2))
			+ OrdW'(day);
		info.year      = year;
		info.jan1      = cur.jan1;
		info.long_cur  = long_year(cur);
		info.long_prev = long_year(prev);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/iwd_week.sv
`default_nettype none

module iwd_week
	import iwd_pkg::*;
(
	input  wire iwd_s1_t info,
	output iwd_res_t     res
);

	logic [WdayW-1:0] wday;
	logic [12:0]      wk_full;
	logic [WeekW-1:0] wk;
	logic [WeekW-1:0] weeks_cur;

	always_comb begin
		wday      = mod7(13'(info.ordinal) + 13'(info.jan1) + 13'd5) + 3'd1;
		wk_full   = div7(13'(info.ordinal) + 13'd10 - 13'(wday));
		wk        = wk_full[WeekW-1:0];
		weeks_cur = info.long_cur ? 6'd53 : 6'd52;

		res.date_valid  = 1'b1;
		res.ordinal_day = info.ordinal;
		res.iso_weekday = wday;
		res.iso_week    = wk;
		res.iso_year    = {1'b0, info.year};

		if (wk == '0) begin
			res.iso_week = info.long_prev ? 6'd53 : 6'd52;
			res.iso_year = {1'b0, info.year} - 13'd1;
		end else if (wk > weeks_cur) begin
			res.iso_week = 6'd1;
			res.iso_year = {1'b0, info.year} + 13'd1;
		end

		if (!info.valid) begin
			res = '0;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/iwd_checker.sv
`default_nettype none

module iwd_checker
	import iwd_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic                date_valid,
	input wire logic [OrdW-1:0]     ordinal_day,
	input wire logic [IsoYearW-1:0] iso_year,
	input wire logic [WeekW-1:0]    iso_week,
	input wire logic [WdayW-1:0]    iso_weekday,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && date_valid |-> ordinal_day >= 9'd1 && ordinal_day <= 9'd366
			&& iso_week >= 6'd1 && iso_week <= 6'd53
			&& iso_weekday >= 3'd1 && iso_weekday <= 3'd7)
		else $error("valid date result out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !date_valid |-> ordinal_day == '0 && iso_year == '0
			&& iso_week == '0 && iso_weekday == '0)
		else $error("invalid date result not zero");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind iso_week_date_converter iwd_checker u_iwd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.date_valid  (result.date_valid),
	.ordinal_day (result.ordinal_day),
	.iso_year    (result.iso_year),
	.iso_week    (result.iso_week),
	.iso_weekday (result.iso_weekday),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

`default_nettype wire
